// ===== hdl/lcb_utf8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_utf8_pkg: shared types and constants of the log capture buffer
// Transaction structs, command codes, UTF-8 masks and the lead byte decoder.
// ----------------------------------------------------------------------------
package lcb_utf8_pkg;

	localparam int unsigned TEXT_BYTES_DEF = 4096;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_STOP = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [7:0] UTF8_M2   = 8'hC0;
	localparam logic [7:0] UTF8_CONT = 8'h80;
	localparam logic [7:0] UTF8_M3   = 8'hE0;
	localparam logic [7:0] UTF8_M4   = 8'hF0;
	localparam logic [7:0] UTF8_M5   = 8'hF8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        push_end;
		logic [11:0] read_index;
	} item_t;

	typedef struct packed {
		logic [12:0] kept_length;
		logic [31:0] dropped_count;
		logic        is_full;
		logic        is_active;
		logic [7:0]  read_byte;
		logic        read_valid;
	} result_t;

	// Length of the character that a byte opens; zero for a continuation byte.
	function automatic logic [2:0] char_len(input logic [7:0] c);
		logic [2:0] n;
		if ((c & UTF8_M2) == UTF8_CONT) begin
			n = 3'd0;
		end else if ((c & UTF8_M3) == UTF8_M2) begin
			n = 3'd2;
		end else if ((c & UTF8_M4) == UTF8_M3) begin
			n = 3'd3;
		end else if ((c & UTF8_M5) == UTF8_M4) begin
			n = 3'd4;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & UTF8_M2) == UTF8_CONT;
	endfunction

endpackage

// ===== hdl/log_capture_buffer_utf8_trim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_capture_buffer_utf8_trim: keep-the-head log capture store
// Appends log bytes to a text memory until full, counts refused bytes and
// trims an incomplete UTF-8 character from the tail on the first overflow.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low, and every
// transaction yields exactly one result, shown on result for the single
// cycle in which done is high; the receiver cannot stall, so it must take
// the result in that cycle. Push, stop and no-operation transactions
// may follow each other in consecutive cycles; their result appears in
// the cycle after acceptance. A read passes through a read state because
// the text memory has registered read data. The push that first finds the
// store full enters a trim state: the tail lookback reads up to four bytes
// one at a time through the memory read port. The text memory is not
// cleared after reset; only bytes below kept_length can be read, and all
// of those have been written.
// ----------------------------------------------------------------------------
module log_capture_buffer_utf8_trim
	import lcb_utf8_pkg::*;
#(
	parameter int unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(TEXT_BYTES);
	localparam int KW = $clog2(TEXT_BYTES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_TRIM = 2'd2;

	// The text store: one write and one read per cycle, registered read data.
	logic [7:0]    mem [TEXT_BYTES];
	logic [7:0]    rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	logic [1:0]    state_q, state_d;
	logic [KW-1:0] kept_q, kept_d;
	logic [31:0]   drop_q, drop_d;
	logic          full_q, full_d;
	logic          halted_q, halted_d;
	logic [1:0]    cont_q, cont_d;
	logic          rvalid_q;
	logic          done_q, done_d;
	result_t       result_q, result_d;

	logic          accept;
	logic          rd_go;
	logic          trim_go;
	logic [31:0]   drop_inc;
	logic [32:0]   drop_sum;
	logic [2:0]    cut_n;
	logic [2:0]    need;
	logic [AW+11:0] idx_wide;
	logic [KW+12:0] kept_wide;
	logic [KW-1:0] look_addr;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// One refused byte, saturating at all ones.
	assign drop_inc = (drop_q == '1) ? drop_q : drop_q + 32'd1;

	// Trimmed bytes: the continuation bytes seen plus their lead byte.
	assign cut_n    = {1'b0, cont_q} + 3'd1;
	assign drop_sum = {1'b0, drop_q} + 33'(cut_n);
	assign need     = char_len(rdata_q);

	assign idx_wide  = {{AW{1'b0}}, item.read_index};
	assign kept_wide = {13'd0, kept_d};

	// Lookback position: kept_q - 2 - cont_q while walking further back.
	assign look_addr = kept_q - KW'(2) - KW'(cont_q);

	always_comb begin
		state_d  = state_q;
		kept_d   = kept_q;
		drop_d   = drop_q;
		full_d   = full_q;
		halted_d = halted_q;
		cont_d   = cont_q;
		done_d   = 1'b0;
		we       = 1'b0;
		rd_go    = 1'b0;
		trim_go  = 1'b0;
		waddr    = kept_q[AW-1:0];
		raddr    = idx_wide[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.kind)
						KIND_PUSH: begin
							if (!halted_q) begin
								if (full_q) begin
									drop_d = drop_inc;
								end else if (kept_q == KW'(TEXT_BYTES)) begin
									full_d  = 1'b1;
									drop_d  = drop_inc;
									trim_go = 1'b1;
								end else begin
									we     = 1'b1;
									kept_d = kept_q + KW'(1);
								end
							end
						end
						KIND_STOP: begin
							halted_d = 1'b1;
						end
						KIND_READ: begin
							rd_go = 1'b1;
						end
						default: begin
						end
					endcase
					if (trim_go) begin
						// Start the lookback at the last kept byte.
						raddr   = AW'(kept_q - KW'(1));
						cont_d  = 2'd0;
						state_d = ST_TRIM;
					end else if (rd_go) begin
						state_d = ST_READ;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_READ: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TRIM: begin
				if (cont_q != 2'd3 && is_cont(rdata_q)) begin
					cont_d = cont_q + 2'd1;
					raddr  = look_addr[AW-1:0];
				end else begin
					// A valid lead byte whose character is not complete is cut.
					if (need != 3'd0 && cut_n < need) begin
						kept_d = kept_q - KW'(cut_n);
						drop_d = drop_sum[32] ? '1 : drop_sum[31:0];
					end
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		result_d.kept_length   = kept_wide[12:0];
		result_d.dropped_count = drop_d;
		result_d.is_full       = full_d;
		result_d.is_active     = !halted_d;
		result_d.read_valid    = (state_q == ST_READ) && rvalid_q;
		result_d.read_byte     = result_d.read_valid ? rdata_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= item.data_byte;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kept_q   <= '0;
			drop_q   <= '0;
			full_q   <= 1'b0;
			halted_q <= 1'b0;
			cont_q   <= 2'd0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			kept_q   <= kept_d;
			drop_q   <= drop_d;
			full_q   <= full_d;
			halted_q <= halted_d;
			cont_q   <= cont_d;
			done_q   <= done_d;
		end
	end

	// Result payload and read qualifier carry no reset.
	always_ff @(posedge clk) begin
		if (done_d) begin
			result_q <= result_d;
		end
		if (rd_go) begin
			rvalid_q <= 32'(item.read_index) < 32'(kept_q);
		end
	end

endmodule

// ===== hdl/lcb_utf8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_utf8_checker: port-level assertions for the log capture buffer
// Checks result timing and counter consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module lcb_utf8_checker
	import lcb_utf8_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// An accepted transaction either finishes at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted transaction neither finished nor went busy");

	// Every multi-cycle transaction ends with its result.
	a_busy_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	// Nothing is dropped before the store has overflowed.
	a_drop_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_full |-> result.dropped_count == 32'd0)
		else $error("bytes dropped without overflow");

	// A valid read implies at least one kept byte.
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.read_valid |-> result.kept_length != 13'd0)
		else $error("valid read from an empty store");

	// A result without a valid read reports no read data.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.read_valid |-> result.read_byte == 8'd0)
		else $error("read data without a valid read");

endmodule

bind log_capture_buffer_utf8_trim lcb_utf8_checker u_lcb_utf8_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
